// File: rtl/slot_allocator_free_stack_unit_assert.svh
// Assertion macros shared by the slot allocator checker.
`ifndef SLOT_ALLOCATOR_FREE_STACK_UNIT_ASSERT_SVH
`define SLOT_ALLOCATOR_FREE_STACK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SAFS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define SAFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/safs_pkg.sv
// Types and constants shared by the slot allocator modules.
package safs_pkg;

    // Fixed field widths of the item ports.
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 10;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 11;

    // Request codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD         = 2'd0,
        ACT_REMOVE_SLOT = 2'd1,
        ACT_REMOVE_ID   = 2'd2,
        ACT_LOOKUP      = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_POP,
        S_SLOT_CHK,
        S_SCAN,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath, one per cycle.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_POP_READ,
        CMD_ADD_POP,
        CMD_ADD_HW,
        CMD_ADD_FULL,
        CMD_SLOT_READ,
        CMD_SLOT_FREE,
        CMD_SLOT_MISS,
        CMD_SCAN_START,
        CMD_SCAN_STEP,
        CMD_ID_FREE,
        CMD_ID_HIT,
        CMD_ID_MISS,
        CMD_EMIT
    } cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        action_t act;
        logic    stack_empty;
        logic    hw_full;
        logic    slot_ok;
        logic    slot_active;
        logic    scan_hit;
        logic    scan_done;
        logic    out_busy;
    } dp_status_t;

endpackage

// File: rtl/slot_allocator_free_stack_unit.sv
// Top level of the slot allocator with a LIFO free stack.
//
//   Channel   Handshake            Fields
//   in        in_valid/in_stall    action, slot_in, particle_id
//   out       out_valid/out_stall  slot_out, status, free_count
//
// Add and remove by slot pass from decode, through a stack pop or slot check where
// one is needed, to emit, and the next item is taken in the cycle after the result
// is loaded. Remove and lookup by id scan the table up to the high-water mark: the
// scan reads one slot per cycle through the single read port of the slot table.
// Reset is immediate; the high-water mark bounds every table read, so no
// clearing pass runs. A new item is taken while the last result waits at the
// output; a stalled output holds the block before it loads the next result.
module slot_allocator_free_stack_unit #(
    parameter int SLOTS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [safs_pkg::ACTION_W-1:0]     action,
    input  logic [safs_pkg::SLOT_W-1:0]       slot_in,
    input  logic [safs_pkg::ID_W-1:0]         particle_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [safs_pkg::SLOT_W-1:0]       slot_out,
    output logic [safs_pkg::STATUS_W-1:0]     status,
    output logic [safs_pkg::FREE_W-1:0]       free_count
);
    import safs_pkg::*;

    cmd_t       cmd;
    dp_status_t dp_stat;

    // Sequencer.
    safs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    // Tables, counters and result register.
    safs_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .slot_in     (slot_in),
        .particle_id (particle_id),
        .cmd         (cmd),
        .dp_stat     (dp_stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot_out    (slot_out),
        .status      (status),
        .free_count  (free_count)
    );

endmodule

// File: rtl/safs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module safs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read first: a read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/safs_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module safs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  safs_pkg::dp_status_t  dp_stat,
    output safs_pkg::cmd_t        cmd
);
    import safs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (dp_stat.act)
                    ACT_ADD:
                    begin
                        state_next = dp_stat.stack_empty ? S_EMIT : S_ADD_POP;
                    end
                    ACT_REMOVE_SLOT:
                    begin
                        state_next = dp_stat.slot_ok ? S_SLOT_CHK : S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_ADD_POP:
            begin
                state_next = S_EMIT;
            end
            S_SLOT_CHK:
            begin
                state_next = S_EMIT;
            end
            S_SCAN:
            begin
                if (dp_stat.scan_hit || dp_stat.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!dp_stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Command and handshake outputs.
    always_comb
    begin
        cmd      = CMD_NONE;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd = CMD_CAPTURE;
                end
            end
            S_DECODE:
            begin
                case (dp_stat.act)
                    ACT_ADD:
                    begin
                        if (!dp_stat.stack_empty)
                        begin
                            cmd = CMD_POP_READ;
                        end
                        else if (!dp_stat.hw_full)
                        begin
                            cmd = CMD_ADD_HW;
                        end
                        else
                        begin
                            cmd = CMD_ADD_FULL;
                        end
                    end
                    ACT_REMOVE_SLOT:
                    begin
                        cmd = dp_stat.slot_ok ? CMD_SLOT_READ : CMD_SLOT_MISS;
                    end
                    default:
                    begin
                        cmd = CMD_SCAN_START;
                    end
                endcase
            end
            S_ADD_POP:
            begin
                cmd = CMD_ADD_POP;
            end
            S_SLOT_CHK:
            begin
                cmd = dp_stat.slot_active ? CMD_SLOT_FREE : CMD_SLOT_MISS;
            end
            S_SCAN:
            begin
                if (dp_stat.scan_hit)
                begin
                    cmd = (dp_stat.act == ACT_REMOVE_ID) ? CMD_ID_FREE : CMD_ID_HIT;
                end
                else if (dp_stat.scan_done)
                begin
                    cmd = CMD_ID_MISS;
                end
                else
                begin
                    cmd = CMD_SCAN_STEP;
                end
            end
            S_EMIT:
            begin
                if (!dp_stat.out_busy)
                begin
                    cmd = CMD_EMIT;
                end
            end
            default:
            begin
                cmd = CMD_NONE;
            end
        endcase
    end

endmodule

// File: rtl/safs_dp.sv
// Datapath: slot table, free stack, counters, id scan and result register.
module safs_dp #(
    parameter int SLOTS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [safs_pkg::ACTION_W-1:0]     action,
    input  logic [safs_pkg::SLOT_W-1:0]       slot_in,
    input  logic [safs_pkg::ID_W-1:0]         particle_id,
    input  safs_pkg::cmd_t                    cmd,
    output safs_pkg::dp_status_t              dp_stat,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [safs_pkg::SLOT_W-1:0]       slot_out,
    output logic [safs_pkg::STATUS_W-1:0]     status,
    output logic [safs_pkg::FREE_W-1:0]       free_count
);
    import safs_pkg::*;

    localparam int SW     = $clog2(SLOTS);
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int DATA_W = ID_W + 1;

    // Captured item.
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [SLOT_W-1:0]   slot_in_reg, slot_in_next;
    logic [ID_W-1:0]     pid_reg, pid_next;

    // Allocation state and id scan.
    logic [CW-1:0]       hw_reg, hw_next;
    logic [CW-1:0]       ftop_reg, ftop_next;
    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [SW-1:0]       cmp_addr_reg, cmp_addr_next;

    // Result of the current item and the output register.
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    status_t             res_st_reg, res_st_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [STATUS_W-1:0] out_st_reg, out_st_next;
    logic [FREE_W-1:0]   out_free_reg, out_free_next;

    // Memory ports.
    logic              ids_we;
    logic [SW-1:0]     ids_waddr;
    logic [DATA_W-1:0] ids_wdata;
    logic [SW-1:0]     ids_raddr;
    logic [DATA_W-1:0] ids_rdata;
    logic              stk_we;
    logic [SW-1:0]     stk_waddr;
    logic [SW-1:0]     stk_wdata;
    logic [SW-1:0]     stk_raddr;
    logic [SW-1:0]     stk_rdata;
    logic [CW-1:0]     ftop_dec;

    // Slot table entries hold the active bit above the id.
    safs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_ids_ram (
        .clk   (clk),
        .we    (ids_we),
        .waddr (ids_waddr),
        .wdata (ids_wdata),
        .raddr (ids_raddr),
        .rdata (ids_rdata)
    );

    // Stack of freed slot numbers.
    safs_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign ftop_dec  = ftop_reg - CW'(1);
    assign stk_raddr = ftop_dec[SW-1:0];

    // Status toward the controller.
    always_comb
    begin
        dp_stat.act         = action_t'(act_reg);
        dp_stat.stack_empty = (ftop_reg == '0);
        dp_stat.hw_full     = (hw_reg == CW'(SLOTS));
        dp_stat.slot_ok     = (CMP_W'(slot_in_reg) < CMP_W'(hw_reg));
        dp_stat.slot_active = ids_rdata[ID_W];
        dp_stat.scan_hit    = cmp_vld_reg && ids_rdata[ID_W]
                              && (ids_rdata[ID_W-1:0] == pid_reg);
        dp_stat.scan_done   = !cmp_vld_reg && (scan_cnt_reg == hw_reg);
        dp_stat.out_busy    = out_valid_reg && out_stall;
    end

    // Command decode and next values.
    always_comb
    begin
        act_next       = act_reg;
        slot_in_next   = slot_in_reg;
        pid_next       = pid_reg;
        hw_next        = hw_reg;
        ftop_next      = ftop_reg;
        scan_cnt_next  = scan_cnt_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_addr_next  = cmp_addr_reg;
        res_slot_next  = res_slot_reg;
        res_st_next    = res_st_reg;
        out_slot_next  = out_slot_reg;
        out_st_next    = out_st_reg;
        out_free_next  = out_free_reg;
        out_valid_next = out_valid_reg && out_stall;
        ids_we         = 1'b0;
        ids_waddr      = SW'(slot_in_reg);
        ids_wdata      = {1'b0, ids_rdata[ID_W-1:0]};
        ids_raddr      = scan_cnt_reg[SW-1:0];
        stk_we         = 1'b0;
        stk_waddr      = ftop_reg[SW-1:0];
        stk_wdata      = SW'(slot_in_reg);
        case (cmd)
            CMD_CAPTURE:
            begin
                act_next     = action;
                slot_in_next = slot_in;
                pid_next     = particle_id;
            end
            CMD_POP_READ:
            begin
                // Stack read address is always the top entry.
                ftop_next = ftop_reg;
            end
            CMD_ADD_POP:
            begin
                ids_we        = 1'b1;
                ids_waddr     = stk_rdata;
                ids_wdata     = {1'b1, pid_reg};
                ftop_next     = ftop_dec;
                res_slot_next = SLOT_W'(stk_rdata);
                res_st_next   = ST_OK;
            end
            CMD_ADD_HW:
            begin
                ids_we        = 1'b1;
                ids_waddr     = hw_reg[SW-1:0];
                ids_wdata     = {1'b1, pid_reg};
                hw_next       = hw_reg + CW'(1);
                res_slot_next = SLOT_W'(hw_reg);
                res_st_next   = ST_OK;
            end
            CMD_ADD_FULL:
            begin
                res_slot_next = '0;
                res_st_next   = ST_FULL;
            end
            CMD_SLOT_READ:
            begin
                ids_raddr = SW'(slot_in_reg);
            end
            CMD_SLOT_FREE:
            begin
                ids_we        = 1'b1;
                stk_we        = 1'b1;
                ftop_next     = ftop_reg + CW'(1);
                res_slot_next = slot_in_reg;
                res_st_next   = ST_OK;
            end
            CMD_SLOT_MISS:
            begin
                res_slot_next = slot_in_reg;
                res_st_next   = ST_MISSING;
            end
            CMD_SCAN_START:
            begin
                scan_cnt_next = '0;
                cmp_vld_next  = 1'b0;
            end
            CMD_SCAN_STEP:
            begin
                // Issue one slot read per cycle; compare it in the next.
                if (scan_cnt_reg < hw_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_addr_next = scan_cnt_reg[SW-1:0];
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
            end
            CMD_ID_FREE:
            begin
                ids_we        = 1'b1;
                ids_waddr     = cmp_addr_reg;
                ids_wdata     = {1'b0, pid_reg};
                stk_we        = 1'b1;
                stk_wdata     = cmp_addr_reg;
                ftop_next     = ftop_reg + CW'(1);
                cmp_vld_next  = 1'b0;
                res_slot_next = SLOT_W'(cmp_addr_reg);
                res_st_next   = ST_OK;
            end
            CMD_ID_HIT:
            begin
                cmp_vld_next  = 1'b0;
                res_slot_next = SLOT_W'(cmp_addr_reg);
                res_st_next   = ST_OK;
            end
            CMD_ID_MISS:
            begin
                res_slot_next = '0;
                res_st_next   = ST_MISSING;
            end
            CMD_EMIT:
            begin
                out_valid_next = 1'b1;
                out_slot_next  = res_slot_reg;
                out_st_next    = res_st_reg;
                out_free_next  = FREE_W'(ftop_reg);
            end
            default:
            begin
                ftop_next = ftop_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg        <= '0;
            ftop_reg      <= '0;
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hw_reg        <= hw_next;
            ftop_reg      <= ftop_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        slot_in_reg  <= slot_in_next;
        pid_reg      <= pid_next;
        cmp_addr_reg <= cmp_addr_next;
        res_slot_reg <= res_slot_next;
        res_st_reg   <= res_st_next;
        out_slot_reg <= out_slot_next;
        out_st_reg   <= out_st_next;
        out_free_reg <= out_free_next;
    end

    assign out_valid  = out_valid_reg;
    assign slot_out   = out_slot_reg;
    assign status     = out_st_reg;
    assign free_count = out_free_reg;

endmodule

// File: rtl/safs_checker.sv
// Port-level checker for the slot allocator and its bind to the top level.
`include "slot_allocator_free_stack_unit_assert.svh"

module safs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [safs_pkg::SLOT_W-1:0]       slot_out,
    input logic [safs_pkg::STATUS_W-1:0]     status,
    input logic [safs_pkg::FREE_W-1:0]       free_count
);
    import safs_pkg::*;

    logic                                in_take;
    logic [SLOT_W+STATUS_W+FREE_W-1:0]   out_word;

    assign in_take  = in_valid && !in_stall;
    assign out_word = {slot_out, status, free_count};

    // A full table can only be reported while nothing waits on the free stack.
    `SAFS_ASSERT_IMPL(a_full_stack_empty, out_valid && (status == ST_FULL), free_count == '0)

    // A full result carries slot zero.
    `SAFS_ASSERT_IMPL(a_full_slot_zero, out_valid && (status == ST_FULL), slot_out == '0)

    // One item at a time: the block is busy right after it takes an item.
    `SAFS_ASSERT_NEXT(a_busy_after_take, in_take, in_stall)

    // A stalled result holds.
    `SAFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind slot_allocator_free_stack_unit safs_checker u_safs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_out    (slot_out),
    .status      (status),
    .free_count  (free_count)
);

// File: tb/tb_top.sv
// Self-checking testbench for the slot allocator with a LIFO free stack.
`timescale 1ns / 100ps

module tb_top;
    import safs_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int HANG_LIMIT = 20000;
    localparam int MAX_PRINTS = 40;

    // One expected result item.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        status_t           st;
        logic [FREE_W-1:0] free_cnt;
    } slot_result_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action      = ACT_ADD;
    logic [SLOT_W-1:0]   slot_in     = '0;
    logic [ID_W-1:0]     particle_id = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_count;

    // Shadow copy of the slot table, the free stack and the high-water mark.
    logic [ID_W-1:0]   tbl_id      [SLOTS];
    bit                tbl_live    [SLOTS];
    logic [SLOT_W-1:0] freed_slots [SLOTS];
    int                freed_depth = 0;
    int                hw_mark     = 0;

    slot_result_t pending_results [$];

    // Idle rates in percent, and the length of a requested output hold-off.
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_request = 0;

    // Bookkeeping for the checker, the watchdog and the summary.
    int mismatch_count  = 0;
    int results_seen    = 0;
    int full_results    = 0;
    int peak_free       = 0;
    int quiet_cycles    = 0;
    int in_stall_cycles = 0;
    int req_count [4]   = '{default: 0};

    slot_allocator_free_stack_unit #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .slot_in(slot_in),
        .particle_id(particle_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .slot_out(slot_out),
        .status(status),
        .free_count(free_count)
    );

    // Free-running clock, 4 ns period.
    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Applies one request to the shadow table and returns the result it must give.
    function automatic slot_result_t apply_slot_request(action_t act,
                                                        logic [SLOT_W-1:0] sel,
                                                        logic [ID_W-1:0] pid);
        slot_result_t res;
        int found;
        int k;
        res.slot = '0;
        res.st   = ST_OK;
        case (act)
            ACT_ADD:
            begin
                // The most recently freed slot goes first, then the high-water mark.
                if (freed_depth > 0)
                begin
                    freed_depth--;
                    res.slot = freed_slots[freed_depth];
                end
                else if (hw_mark < SLOTS)
                begin
                    res.slot = SLOT_W'(hw_mark);
                    hw_mark++;
                end
                else
                begin
                    res.st = ST_FULL;
                end
                if (res.st == ST_OK)
                begin
                    tbl_id[res.slot]   = pid;
                    tbl_live[res.slot] = 1'b1;
                end
            end
            ACT_REMOVE_SLOT:
            begin
                res.slot = sel;
                if (int'(sel) < hw_mark && tbl_live[sel])
                begin
                    tbl_live[sel]            = 1'b0;
                    freed_slots[freed_depth] = sel;
                    freed_depth++;
                end
                else
                begin
                    res.st = ST_MISSING;
                end
            end
            default:
            begin
                // Lowest-numbered active slot that holds the id.
                found = -1;
                for (k = 0; k < hw_mark && found < 0; k++)
                begin
                    if (tbl_live[k] && tbl_id[k] == pid)
                        found = k;
                end
                if (found < 0)
                begin
                    res.st = ST_MISSING;
                end
                else
                begin
                    res.slot = SLOT_W'(found);
                    if (act == ACT_REMOVE_ID)
                    begin
                        tbl_live[found]          = 1'b0;
                        freed_slots[freed_depth] = SLOT_W'(found);
                        freed_depth++;
                    end
                end
            end
        endcase
        res.free_cnt = FREE_W'(freed_depth);
        return res;
    endfunction

    // Ids lean toward the extremes and a few small values, so duplicates are common.
    function automatic logic [ID_W-1:0] random_id();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return ID_W'($urandom_range(7));
            default: return ID_W'($urandom());
        endcase
    endfunction

    // Returns some active slot, or -1 when none is active.
    function automatic int pick_live_slot();
        int start;
        int idx;
        int k;
        if (hw_mark == freed_depth)
            return -1;
        start = $urandom_range(hw_mark - 1);
        for (k = 0; k < hw_mark; k++)
        begin
            idx = (start + k) % hw_mark;
            if (tbl_live[idx])
                return idx;
        end
        return -1;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
    endtask

    // Offers one item after an optional random gap and records it once taken.
    // Valid stays high on return, so back-to-back items need no extra cycle.
    task automatic send_item(action_t act, logic [SLOT_W-1:0] sel, logic [ID_W-1:0] pid);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid    <= 1'b1;
        action      <= act;
        slot_in     <= sel;
        particle_id <= pid;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.insert(pending_results.size(), apply_slot_request(act, sel, pid));
        req_count[int'(act)]++;
    endtask

    // Stops offering items and waits until every expected result is back.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin : rx_side
        int hold;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold         = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        slot_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: slot %0d status %0d",
                                          slot_out, status));
            end
            else
            begin
                want = pending_results.pop_front();
                if (slot_out !== want.slot)
                    report_mismatch($sformatf("slot_out %0d, expected %0d",
                                              slot_out, want.slot));
                if (status !== want.st)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.st));
                if (free_count !== want.free_cnt)
                    report_mismatch($sformatf("free_count %0d, expected %0d",
                                              free_count, want.free_cnt));
                if (want.st == ST_FULL)
                    full_results++;
                if (int'(want.free_cnt) > peak_free)
                    peak_free = int'(want.free_cnt);
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (in_valid && in_stall)
            in_stall_cycles++;
        if (quiet_cycles == HANG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Extreme field values, each operation and each miss and reuse case.
    task automatic test_directed();
        send_item(ACT_LOOKUP, '0, '1);                  // empty table, no match
        send_item(ACT_REMOVE_ID, '0, '0);
        send_item(ACT_REMOVE_SLOT, '0, '0);             // never allocated
        send_item(ACT_REMOVE_SLOT, '1, '0);
        send_item(ACT_ADD, '0, '0);                     // slot 0 from the high-water mark
        send_item(ACT_ADD, '1, '1);
        send_item(ACT_ADD, '0, 32'hA5A5_A5A5);
        send_item(ACT_ADD, '0, '1);                     // duplicate id in slot 3
        send_item(ACT_LOOKUP, '0, '1);                  // lowest match wins
        send_item(ACT_REMOVE_ID, '0, '1);
        send_item(ACT_LOOKUP, '0, '1);                  // now the later duplicate
        send_item(ACT_REMOVE_SLOT, 10'd1, '0);          // already free
        send_item(ACT_REMOVE_SLOT, 10'd2, '0);
        send_item(ACT_REMOVE_SLOT, 10'h2AA, '0);
        send_item(ACT_REMOVE_SLOT, 10'h155, '0);
        send_item(ACT_ADD, '0, 32'h5A5A_5A5A);          // reuses slot 2, last freed
        send_item(ACT_ADD, '0, 32'h1234_5678);          // then slot 1
        send_item(ACT_ADD, '0, '0);                     // stack empty again
        send_item(ACT_LOOKUP, '0, '0);
        send_item(ACT_REMOVE_ID, '0, 32'hA5A5_A5A5);    // id was overwritten
        send_item(ACT_REMOVE_SLOT, 10'd0, '0);
        send_item(ACT_REMOVE_SLOT, 10'd0, '0);
        send_item(ACT_LOOKUP, '0, '0);
        send_item(ACT_REMOVE_ID, '0, '0);
    endtask

    // Mostly requests that hit active slots and ids, with random noise mixed in.
    task automatic test_random_mix(int n_items, int search_pct);
        int r;
        int pick;
        int add_pct;
        action_t act;
        logic [SLOT_W-1:0] sel;
        logic [ID_W-1:0] pid;
        repeat (n_items)
        begin
            r       = $urandom_range(99);
            pick    = pick_live_slot();
            sel     = SLOT_W'($urandom_range(SLOTS - 1));
            pid     = random_id();
            // Favor adds while few slots are active, so the table keeps some depth.
            add_pct = ((hw_mark - freed_depth) < 32) ? 60 : 45;
            if (r < search_pct)
            begin
                act = ($urandom_range(1) != 0) ? ACT_REMOVE_ID : ACT_LOOKUP;
                if (pick >= 0 && $urandom_range(3) != 0)
                    pid = tbl_id[pick];
            end
            else if (r < search_pct + (100 - search_pct) * add_pct / 100)
            begin
                act = ACT_ADD;
                if (pick >= 0 && $urandom_range(3) == 0)
                    pid = tbl_id[pick];
            end
            else
            begin
                act = ACT_REMOVE_SLOT;
                if (pick >= 0 && $urandom_range(4) != 0)
                    sel = SLOT_W'(pick);
            end
            send_item(act, sel, pid);
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        hold_request = 300;
        test_random_mix(16, 20);
        wait_all_results();
    endtask

    // Test sequence.
    initial
    begin : main_seq
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 28;
        rcv_idle_pct = 52;
        test_directed();
        test_random_mix(220, 40);
        test_output_backpressure();

        snd_idle_pct = 52;
        rcv_idle_pct = 28;
        test_random_mix(220, 40);
        wait_all_results();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_mix(100, 12);
        wait_all_results();
        repeat (64) @(posedge clk);

        $display("Checked %0d results: %0d add, %0d remove by slot, %0d remove by id, %0d lookup.",
                 results_seen, req_count[ACT_ADD], req_count[ACT_REMOVE_SLOT],
                 req_count[ACT_REMOVE_ID], req_count[ACT_LOOKUP]);
        $display("High-water %0d, peak free count %0d, full results %0d, input stall cycles %0d.",
                 hw_mark, peak_free, full_results, in_stall_cycles);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
